### rtl/core/mf3_pkg.sv
package mf3_pkg;

	localparam int PIX_W = 8;
	localparam int POS_W = 10;
	localparam int CFG_W = 11;
	localparam int IDX_W = 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef logic [PIX_W-1:0] pix_t;

	// which results one request causes
	typedef struct packed {
		logic lag;       // lagging result at (r-1, c-1)
		logic interior;  // lagging result is a median, not a border copy
		logic rend_res;  // right border copy at (r-1, c)
		logic last_row;  // bottom row copy at (r, c)
		logic frame_end; // last column of the last row
	} emit_t;

	function automatic pix_t pmin(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pmax(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return pmax(pmin(a, b), pmin(pmax(a, b), c));
	endfunction

endpackage

### rtl/core/median_filter_3x3_unit.sv
// 3x3 median filter for 8-bit grey frames, one pixel per clock.
// Input: pixel on a valid/ready channel, in raster order of a frame of
// frame_width x frame_height pixels (config register 0 and 1, written
// through cfg_we/cfg_index/cfg_wdata while the block is idle).
// Output: value, out_row, out_col, last_of_run and frame_done on a
// valid/ready channel. Interior pixels are replaced by the median of
// their neighborhood, border pixels are passed through unchanged.
// Each request gives 0 to 3 results; results trail the input by one row
// and one column, with the bottom row and right column flushed as they go.
// Throughput: one request per cycle while each gives at most one result
// and out_ready stays high; the output port moves one result per cycle,
// so a request giving more results stops the input until its last one is
// taken. A two-row line store (one registered read and one write port)
// and a 3-stage median network set this.
// Reset clears counters, window and pipeline, and sets both dimensions
// to 1024. The line store is not cleared. When the receiver stalls, the
// whole pipeline holds and in_ready stays low while any result waits in
// the output stage.
module median_filter_3x3_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mf3_pkg::IDX_W-1:0]  cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mf3_pkg::PIX_W-1:0]  pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mf3_pkg::PIX_W-1:0]  value,
	output logic [mf3_pkg::POS_W-1:0]  out_row,
	output logic [mf3_pkg::POS_W-1:0]  out_col,
	output logic                       last_of_run,
	output logic                       frame_done
);
	import mf3_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WCLW = $clog2(MAX_WIDTH + 1);
	localparam int HCLW = $clog2(MAX_HEIGHT + 1);
	localparam int WW   = (WCLW > CFG_W) ? WCLW : CFG_W;
	localparam int HW   = (HCLW > CFG_W) ? HCLW : CFG_W;

	// configuration
	logic [CFG_W-1:0] width_q, height_q;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// pipeline control
	logic adv, accept;
	logic v_s1, v_s2, v_s3;
	emit_t emit_in, fl_s1, fl_s2, fl_s3;

	// line store: {older, newer} per column
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] mem_rd_q, fwd_data_q, rd_word;
	logic               fwd_q;
	logic               wr_en;

	// stage 1
	pix_t          pix_s1, top, mid;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	pix_t          win0_q [3];
	pix_t          win1_q [3];
	pix_t          col_v  [3][3];
	pix_t          lo_n [3], md_n [3], hi_n [3];

	// stage 2
	pix_t          lo_s2 [3], md_s2 [3], hi_s2 [3];
	pix_t          wmid_s2, mid_s2, pix_s2;
	logic [CW-1:0] c_s2;
	logic [RW-1:0] r_s2;

	// stage 3
	pix_t          lo_s3, md_s3, hi_s3;
	pix_t          wmid_s3, mid_s3, pix_s3;
	logic [CW-1:0] c_s3;
	logic [RW-1:0] r_s3;

	// output stage
	logic [2:0]    mask_q, mask_rest;
	pix_t          val_q [3];
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic          fd_q;
	logic          pop_last;
	pix_t          lag_val;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: height_q <= cfg_wdata;
			endcase
		end
	end

	// saturate dimensions to [1, max]
	always_comb begin
		if (width_q == '0)
			w_eff = WW'(1);
		else if (WW'(width_q) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		if (height_q == '0)
			h_eff = HW'(1);
		else if (HW'(height_q) > HW'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(height_q);
	end

	// result schedule for the incoming request
	always_comb begin
		emit_in.lag       = (row_q != '0) && (col_q != '0);
		emit_in.interior  = (row_q >= RW'(2)) && (col_q >= CW'(2)) &&
			(WW'(col_q) < w_eff) && (HW'(row_q) < h_eff);
		emit_in.rend_res  = (row_q != '0) && ((WW'(col_q) + WW'(1)) >= w_eff);
		emit_in.last_row  = (HW'(row_q) + HW'(1)) >= h_eff;
		emit_in.frame_end = ((WW'(col_q) + WW'(1)) >= w_eff) && emit_in.last_row;
	end

	// handshake: advance when the output stage will be empty
	assign mask_rest = mask_q & (mask_q - 3'd1);
	assign pop_last  = (mask_rest == 3'd0);
	assign adv       = (mask_q == 3'd0) || (out_ready && pop_last);
	assign in_ready  = adv;
	assign accept    = in_valid && adv;
	assign wr_en     = adv && v_s1;

	// counters, valids, window, output mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			mask_q <= 3'd0;
			for (int i = 0; i < 3; i++) begin
				win0_q[i] <= '0;
				win1_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				if ((WW'(col_q) + WW'(1)) >= w_eff) begin
					col_q <= '0;
					row_q <= emit_in.last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				mask_q <= v_s3 ? {fl_s3.last_row, fl_s3.rend_res, fl_s3.lag} : 3'd0;
			end else if (out_valid && out_ready) begin
				mask_q <= mask_rest;
			end
			if (wr_en) begin
				for (int i = 0; i < 3; i++)
					win1_q[i] <= win0_q[i];
				win0_q[0] <= top;
				win0_q[1] <= mid;
				win0_q[2] <= pix_s1;
			end
		end
	end

	// line store with read-during-write bypass
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[c_s1] <= {mid, pix_s1};
		if (accept) begin
			mem_rd_q   <= line_mem[col_q];
			fwd_q      <= wr_en && (c_s1 == col_q);
			fwd_data_q <= {mid, pix_s1};
		end
	end

	assign rd_word = fwd_q ? fwd_data_q : mem_rd_q;
	assign top     = rd_word[2*PIX_W-1:PIX_W];
	assign mid     = rd_word[PIX_W-1:0];

	// sort each column of the neighborhood
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col_v[0][i] = win1_q[i];
			col_v[1][i] = win0_q[i];
		end
		col_v[2][0] = top;
		col_v[2][1] = mid;
		col_v[2][2] = pix_s1;
		for (int j = 0; j < 3; j++) begin
			lo_n[j] = pmin(pmin(col_v[j][0], col_v[j][1]), col_v[j][2]);
			hi_n[j] = pmax(pmax(col_v[j][0], col_v[j][1]), col_v[j][2]);
			md_n[j] = med3(col_v[j][0], col_v[j][1], col_v[j][2]);
		end
	end

	// lagging value: median inside, copied pixel on the border
	assign lag_val = fl_s3.interior ? med3(lo_s3, md_s3, hi_s3) : wmid_s3;

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pixel;
			c_s1   <= col_q;
			r_s1   <= row_q;
			fl_s1  <= emit_in;

			for (int j = 0; j < 3; j++) begin
				lo_s2[j] <= lo_n[j];
				md_s2[j] <= md_n[j];
				hi_s2[j] <= hi_n[j];
			end
			wmid_s2 <= win0_q[1];
			mid_s2  <= mid;
			pix_s2  <= pix_s1;
			c_s2    <= c_s1;
			r_s2    <= r_s1;
			fl_s2   <= fl_s1;

			lo_s3   <= pmax(pmax(lo_s2[0], lo_s2[1]), lo_s2[2]);
			md_s3   <= med3(md_s2[0], md_s2[1], md_s2[2]);
			hi_s3   <= pmin(pmin(hi_s2[0], hi_s2[1]), hi_s2[2]);
			wmid_s3 <= wmid_s2;
			mid_s3  <= mid_s2;
			pix_s3  <= pix_s2;
			c_s3    <= c_s2;
			r_s3    <= r_s2;
			fl_s3   <= fl_s2;

			val_q[0] <= lag_val;
			val_q[1] <= mid_s3;
			val_q[2] <= pix_s3;
			c_q      <= c_s3;
			r_q      <= r_s3;
			fd_q     <= fl_s3.frame_end;
		end
	end

	// present the lowest pending result
	always_comb begin
		out_valid   = (mask_q != 3'd0);
		last_of_run = out_valid && pop_last;
		frame_done  = last_of_run && fd_q;
		if (mask_q[0]) begin
			value   = val_q[0];
			out_row = POS_W'(r_q - RW'(1));
			out_col = POS_W'(c_q - CW'(1));
		end else if (mask_q[1]) begin
			value   = val_q[1];
			out_row = POS_W'(r_q - RW'(1));
			out_col = POS_W'(c_q);
		end else begin
			value   = val_q[2];
			out_row = POS_W'(r_q);
			out_col = POS_W'(c_q);
		end
	end

endmodule

### rtl/core/mf3_checker.sv
module mf3_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [mf3_pkg::PIX_W-1:0]  value,
	input logic [mf3_pkg::POS_W-1:0]  out_row,
	input logic [mf3_pkg::POS_W-1:0]  out_col,
	input logic                       last_of_run,
	input logic                       frame_done
);
	import mf3_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) &&
			$stable(out_row) && $stable(out_col) && $stable(last_of_run))
		else $error("stalled result changed");

	// frame end is only flagged on the last result of a run
	a_fd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// an empty output stage always takes a request
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a run keeps going until its last result
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("run ended early");

	// while more results of a run wait, no new request is taken
	a_run_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("request taken during a run");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (.*);
